/* rtl/ira_pkg.sv */
// ira_pkg: state codes for the interval room allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ira_pkg;
	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_SRD   = 4'd1;
	localparam logic [3:0] ST_SCMP  = 4'd2;
	localparam logic [3:0] ST_WRD   = 4'd3;
	localparam logic [3:0] ST_WDEC  = 4'd4;
	localparam logic [3:0] ST_HRD   = 4'd5;
	localparam logic [3:0] ST_HCMP  = 4'd6;
	localparam logic [3:0] ST_ORD   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_SWAIT = 4'd9;
	localparam logic [3:0] ST_WWAIT = 4'd10;
	localparam logic [3:0] ST_OWAIT = 4'd11;
endpackage
`default_nettype wire

/* rtl/interval_room_allocator.sv */
// interval_room_allocator: top level, loading, insertion sort, heap walk and result output.
// Depends on ira_pkg.
//
// Usage: intervals arrive on the input channel (arrival, departure, last),
// one transaction per cycle while loading. The transaction with last set, or
// the one that fills the store of MAX_REQUESTS entries, closes the set.
// The block then sorts the set by insertion sort, O(n^2) worst case. It
// then walks the set with a min-heap held in a memory with one read and one
// write per cycle: an insert sifts up one level at a time, and a replaced
// top sifts down one level at a time. Results leave in load order, one at a
// time, each taken before the next is read from the registered room memory
// port; final_res marks the last. Input stall is high from the closing
// transaction until the last result is taken. A stalled result holds its
// payload. Reset clears the state register, the load count and out_valid
// only; memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module interval_room_allocator #(
	parameter int MAX_REQUESTS = 64,
	parameter int TIME_BITS    = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] arrival,
	input  wire  [31:0] departure,
	input  wire         last,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [5:0]  request_index,
	output logic [5:0]  room,
	output logic [6:0]  room_count,
	output logic        final_res
);
	import ira_pkg::*;
	localparam int IW = $clog2(MAX_REQUESTS);
	localparam int CW = IW + 1;
	localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

	logic [TW-1:0] arr_mem [MAX_REQUESTS];
	logic [TW-1:0] dep_mem [MAX_REQUESTS];
	logic [IW-1:0] ord_mem [MAX_REQUESTS];
	logic [IW-1:0] room_mem [MAX_REQUESTS];
	logic [TW+IW-1:0] heap_mem [MAX_REQUESTS];

	logic [3:0] st_q;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q, hsz_q, rooms_q, k_q;
	logic [IW-1:0] v_q;
	logic [TW-1:0] va_q, vd_q;
	logic [TW+IW-1:0] hk_q, top_q, best_q;
	logic [CW-1:0] best_i_q;
	logic [1:0] hph_q;
	logic popmode_q;

	// memory read ports
	logic [IW-1:0] ard_a, ord_a, hrd_a, rrd_a;
	logic [TW-1:0] ard_d, drd_d;
	logic [IW-1:0] ord_d, rrd_d;
	logic [TW+IW-1:0] hrd_d;

	logic in_acc;
	assign in_stall = (st_q != ST_LOAD);
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		ard_d <= arr_mem[ard_a];
		drd_d <= dep_mem[ard_a];
		ord_d <= ord_mem[ord_a];
		hrd_d <= heap_mem[hrd_a];
		rrd_d <= room_mem[rrd_a];
		if (in_acc) begin
			arr_mem[cnt_q[IW-1:0]] <= arrival[TW-1:0];
			dep_mem[cnt_q[IW-1:0]] <= departure[TW-1:0];
		end
	end

	function automatic logic hless(logic [TW+IW-1:0] a, logic [TW+IW-1:0] b);
		return a < b;
	endfunction

	logic [CW-1:0] ch_l, ch_r;
	assign ch_l = {k_q[CW-2:0], 1'b1};
	assign ch_r = ch_l + CW'(1);

	always_comb begin
		ard_a = v_q;
		ord_a = j_q[IW-1:0] - IW'(1);
		hrd_a = '0;
		rrd_a = i_q[IW-1:0];
		case (st_q)
			ST_SWAIT: ard_a = ord_d;
			ST_WRD, ST_WWAIT: begin
				ord_a = i_q[IW-1:0];
				ard_a = ord_d;
			end
			ST_HRD: hrd_a = (hph_q == 2'd0) ? ch_l[IW-1:0] :
				(hph_q == 2'd1) ? ch_r[IW-1:0] : ((k_q[IW-1:0] - IW'(1)) >> 1);
			default: ;
		endcase
	end

	logic v_first;
	always_comb begin
		if (va_q != ard_d) v_first = va_q < ard_d;
		else if (vd_q != drd_d) v_first = vd_q < drd_d;
		else v_first = v_q < ord_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				ST_LOAD: if (in_acc) begin
					cnt_q <= cnt_q + CW'(1);
					if (last || cnt_q == CW'(MAX_REQUESTS - 1)) begin
						n_q <= cnt_q + CW'(1);
						i_q <= '0;
						st_q <= ST_SRD;
						v_q <= '0;
						j_q <= '0;
						hph_q <= 2'd3;
					end
				end
				ST_SRD: begin
					// hph_q==3: fetch element i values
					if (hph_q == 2'd3) begin
						if (i_q == n_q) begin
							i_q <= '0;
							hsz_q <= '0;
							rooms_q <= '0;
							st_q <= ST_WRD;
						end else begin
							v_q <= i_q[IW-1:0];
							j_q <= i_q;
							hph_q <= 2'd2;
						end
					end else if (hph_q == 2'd2) begin
						hph_q <= 2'd1;
					end else if (hph_q == 2'd1) begin
						va_q <= ard_d;
						vd_q <= drd_d;
						hph_q <= 2'd0;
						st_q <= ST_SWAIT;
					end else begin
						// hph_q==0: ord_mem read of the new j-1 after a shift
						st_q <= ST_SWAIT;
					end
				end
				ST_SWAIT: st_q <= ST_SCMP;
				ST_SCMP: begin
					// ord_d and its values are valid for j-1
					if (j_q != '0 && v_first) begin
						ord_mem[j_q[IW-1:0]] <= ord_d;
						j_q <= j_q - CW'(1);
						st_q <= ST_SRD;
					end else begin
						ord_mem[j_q[IW-1:0]] <= v_q;
						i_q <= i_q + CW'(1);
						hph_q <= 2'd3;
						st_q <= ST_SRD;
					end
				end
				ST_WRD: begin
					if (i_q == n_q) begin
						i_q <= '0;
						st_q <= ST_ORD;
					end else st_q <= ST_WWAIT;
				end
				ST_WWAIT: st_q <= ST_WDEC;
				ST_WDEC: begin
					if (hsz_q == '0 || top_q[TW+IW-1:IW] >= ard_d) begin
						room_mem[ord_d] <= rooms_q[IW-1:0];
						hk_q <= {drd_d, rooms_q[IW-1:0]};
						rooms_q <= rooms_q + CW'(1);
						k_q <= hsz_q;
						hsz_q <= hsz_q + CW'(1);
						popmode_q <= 1'b0;
						hph_q <= 2'd2;
					end else begin
						room_mem[ord_d] <= top_q[IW-1:0];
						hk_q <= {drd_d, top_q[IW-1:0]};
						k_q <= '0;
						popmode_q <= 1'b1;
						hph_q <= 2'd0;
					end
					st_q <= ST_HRD;
				end
				ST_HRD: begin
					if (!popmode_q && k_q == '0) begin
						heap_mem[0] <= hk_q;
						top_q <= hk_q;
						i_q <= i_q + CW'(1);
						st_q <= ST_WRD;
					end else if (popmode_q && (ch_l >= hsz_q || hph_q == 2'd1)) begin
						if (ch_l >= hsz_q) begin
							heap_mem[k_q[IW-1:0]] <= hk_q;
							if (k_q == '0) top_q <= hk_q;
							i_q <= i_q + CW'(1);
							st_q <= ST_WRD;
						end else begin
							st_q <= ST_HCMP;
						end
					end else st_q <= ST_HCMP;
				end
				ST_HCMP: begin
					if (!popmode_q) begin
						if (hless(hk_q, hrd_d)) begin
							heap_mem[k_q[IW-1:0]] <= hrd_d;
							k_q <= (k_q - CW'(1)) >> 1;
							st_q <= ST_HRD;
						end else begin
							heap_mem[k_q[IW-1:0]] <= hk_q;
							i_q <= i_q + CW'(1);
							st_q <= ST_WRD;
						end
					end else if (hph_q == 2'd0) begin
						best_q <= hrd_d;
						best_i_q <= ch_l;
						if (ch_r < hsz_q) begin
							hph_q <= 2'd1;
							st_q <= ST_HRD;
						end else begin
							hph_q <= 2'd3;
							st_q <= ST_HCMP;
						end
					end else begin
						logic [TW+IW-1:0] b;
						logic [CW-1:0] bi;
						b = best_q;
						bi = best_i_q;
						if (hph_q == 2'd1 && hless(hrd_d, b)) begin
							b = hrd_d;
							bi = ch_r;
						end
						if (hless(b, hk_q)) begin
							heap_mem[k_q[IW-1:0]] <= b;
							if (k_q == '0) top_q <= b;
							k_q <= bi;
							hph_q <= 2'd0;
							st_q <= ST_HRD;
						end else begin
							heap_mem[k_q[IW-1:0]] <= hk_q;
							if (k_q == '0) top_q <= hk_q;
							i_q <= i_q + CW'(1);
							st_q <= ST_WRD;
						end
					end
				end
				ST_ORD: st_q <= ST_OWAIT;
				ST_OWAIT: begin
					out_valid <= 1'b1;
					request_index <= 6'(i_q);
					room <= 6'(rrd_d);
					room_count <= 7'(rooms_q);
					final_res <= (i_q + CW'(1) == n_q);
					st_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					if (i_q + CW'(1) == n_q) begin
						cnt_q <= '0;
						st_q <= ST_LOAD;
					end else begin
						i_q <= i_q + CW'(1);
						st_q <= ST_ORD;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire
